@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define OBBC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Clocked assertion, also checked during reset.
`define OBBC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

@@ src/obbc_pkg.sv @@
// ----------------------------------------------------------------------------
// obbc_pkg
// Widths, types and the dot-product pairing table of the overlap test.
// ----------------------------------------------------------------------------
package obbc_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int DOT_W       = PROD_W + 1;
  localparam int ACC_W       = DOT_W + 2;
  localparam int RS_W        = COORD_WIDTH + 1;
  localparam int R2_W        = 2 * RS_W;

  localparam int NUM_EDGE    = 4;
  localparam int NUM_VEC     = NUM_EDGE + 1;
  localparam int NUM_DOT     = NUM_VEC * (NUM_VEC + 1) / 2;
  localparam int CENTER      = NUM_EDGE;

  // Slot of the shared dot product of vectors i and j (edges 0..3, center 4).
  localparam int PAIR_IDX [NUM_VEC][NUM_VEC] = '{
    '{0, 1, 2,  3,  4},
    '{1, 5, 6,  7,  8},
    '{2, 6, 9,  10, 11},
    '{3, 7, 10, 12, 13},
    '{4, 8, 11, 13, 14}
  };

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DOT_W-1:0]       dsum_t;
  typedef logic        [DOT_W-1:0]       dmag_t;
  typedef logic        [ACC_W-1:0]       acc_t;
  typedef logic signed [RS_W-1:0]        rs_t;
  typedef logic signed [R2_W-1:0]        r2_t;
  typedef logic        [R2_W-1:0]        r2u_t;

  // Stage load enables handed to the dot-product units.
  typedef struct packed {
    logic s2;
    logic s3;
  } adv_t;

endpackage

@@ src/obbc_if.sv @@
// ----------------------------------------------------------------------------
// obbc_if
// Valid/ready channels: collider pair request and overlap response.
// ----------------------------------------------------------------------------
interface obbc_req_if;
  logic            valid;
  logic            ready;
  logic            kind;
  obbc_pkg::coord_t left_ux;
  obbc_pkg::coord_t left_uy;
  obbc_pkg::coord_t left_vx;
  obbc_pkg::coord_t left_vy;
  obbc_pkg::coord_t right_ux;
  obbc_pkg::coord_t right_uy;
  obbc_pkg::coord_t right_vx;
  obbc_pkg::coord_t right_vy;
  obbc_pkg::coord_t center_dx;
  obbc_pkg::coord_t center_dy;

  modport source (
    output valid, kind, left_ux, left_uy, left_vx, left_vy,
           right_ux, right_uy, right_vx, right_vy, center_dx, center_dy,
    input  ready
  );
  modport sink (
    input  valid, kind, left_ux, left_uy, left_vx, left_vy,
           right_ux, right_uy, right_vx, right_vy, center_dx, center_dy,
    output ready
  );
endinterface

interface obbc_rsp_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);
endinterface

@@ src/obbc_dot.sv @@
// ----------------------------------------------------------------------------
// obbc_dot
// Two-stage |a.b| unit: registered products, then registered magnitude.
// ----------------------------------------------------------------------------
module obbc_dot (
  input  logic             clk_i,
  input  obbc_pkg::adv_t   adv_i,
  input  obbc_pkg::coord_t ax_i,
  input  obbc_pkg::coord_t ay_i,
  input  obbc_pkg::coord_t bx_i,
  input  obbc_pkg::coord_t by_i,
  output obbc_pkg::dmag_t  mag_o
);

  obbc_pkg::prod_t pa_q;
  obbc_pkg::prod_t pb_q;
  obbc_pkg::dsum_t sum;
  obbc_pkg::dmag_t mag_d;
  obbc_pkg::dmag_t mag_q;

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      pa_q <= ax_i * bx_i;
      pb_q <= ay_i * by_i;
    end
  end

  always_comb begin
    sum   = obbc_pkg::dsum_t'(pa_q) + obbc_pkg::dsum_t'(pb_q);
    mag_d = sum[obbc_pkg::DOT_W-1] ? obbc_pkg::dmag_t'(-sum) : obbc_pkg::dmag_t'(sum);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      mag_q <= mag_d;
    end
  end

  assign mag_o = mag_q;

endmodule

@@ src/obb_circle_overlap_test_2d_core.sv @@
// ----------------------------------------------------------------------------
// obb_circle_overlap_test_2d_core: box/box separating-axis and circle test.
// Five register stages from request beat to response beat.
// Throughput: one beat per cycle; each stage holds under backpressure.
// Reset: asynchronous, clears the stage valid bits only.
// ----------------------------------------------------------------------------
module obb_circle_overlap_test_2d_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  obbc_req_if.sink   req_i,
  obbc_rsp_if.source rsp_o
);

  logic [5:1] vld_q;
  logic [5:1] vld_d;
  logic [5:1] load;
  logic [4:1] kind_q;

  obbc_pkg::adv_t   adv;
  obbc_pkg::coord_t x_q [obbc_pkg::NUM_VEC];
  obbc_pkg::coord_t y_q [obbc_pkg::NUM_VEC];
  obbc_pkg::dmag_t  dot_mag [obbc_pkg::NUM_DOT];

  obbc_pkg::rs_t    rs_q;
  obbc_pkg::r2_t    r2_q;
  obbc_pkg::r2u_t   r2u_q;
  obbc_pkg::dmag_t  d2_q;
  obbc_pkg::acc_t   acc_q  [obbc_pkg::NUM_EDGE];
  obbc_pkg::acc_t   cen2_q [obbc_pkg::NUM_EDGE];

  logic sep;
  logic ovl_d;
  logic ovl_q;

  // stage control: a stage loads when empty or when its successor loads
  always_comb begin
    load[5] = !vld_q[5] || rsp_o.ready;
    for (int k = 4; k >= 1; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
    vld_d[1] = load[1] ? req_i.valid : vld_q[1];
    for (int k = 2; k <= 5; k++) begin
      vld_d[k] = load[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign req_i.ready = load[1];
  assign adv.s2      = load[2];
  assign adv.s3      = load[3];

  // stage 1: capture the beat
  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      kind_q[1] <= req_i.kind;
      x_q[0]    <= req_i.left_ux;
      y_q[0]    <= req_i.left_uy;
      x_q[1]    <= req_i.left_vx;
      y_q[1]    <= req_i.left_vy;
      x_q[2]    <= req_i.right_ux;
      y_q[2]    <= req_i.right_uy;
      x_q[3]    <= req_i.right_vx;
      y_q[3]    <= req_i.right_vy;
      x_q[4]    <= req_i.center_dx;
      y_q[4]    <= req_i.center_dy;
    end
  end

  // stages 2-3: every distinct dot product among edges and center offset
  for (genvar i = 0; i < obbc_pkg::NUM_VEC; i++) begin : g_row
    for (genvar j = i; j < obbc_pkg::NUM_VEC; j++) begin : g_col
      obbc_dot u_dot (
        .clk_i (clk_i),
        .adv_i (adv),
        .ax_i  (x_q[i]),
        .ay_i  (y_q[i]),
        .bx_i  (x_q[j]),
        .by_i  (y_q[j]),
        .mag_o (dot_mag[obbc_pkg::PAIR_IDX[i][j]])
      );
    end
  end

  // stages 2-3: squared radius sum
  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      kind_q[2] <= kind_q[1];
      rs_q      <= obbc_pkg::rs_t'(x_q[0]) + obbc_pkg::rs_t'(x_q[2]);
    end
    if (load[3]) begin
      kind_q[3] <= kind_q[2];
      r2_q      <= rs_q * rs_q;
    end
  end

  // stage 4: per-axis projected extent, doubled projected center distance and circle-test operands
  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      kind_q[4] <= kind_q[3];
      r2u_q     <= obbc_pkg::r2u_t'(r2_q);
      d2_q      <= dot_mag[obbc_pkg::PAIR_IDX[obbc_pkg::CENTER][obbc_pkg::CENTER]];
      for (int i = 0; i < obbc_pkg::NUM_EDGE; i++) begin
        acc_q[i]  <= (obbc_pkg::acc_t'(dot_mag[obbc_pkg::PAIR_IDX[i][0]])
                    + obbc_pkg::acc_t'(dot_mag[obbc_pkg::PAIR_IDX[i][1]]))
                   + (obbc_pkg::acc_t'(dot_mag[obbc_pkg::PAIR_IDX[i][2]])
                    + obbc_pkg::acc_t'(dot_mag[obbc_pkg::PAIR_IDX[i][3]]));
        cen2_q[i] <= obbc_pkg::acc_t'(
                       {dot_mag[obbc_pkg::PAIR_IDX[i][obbc_pkg::CENTER]], 1'b0});
      end
    end
  end

  // stage 5: compare and select by kind
  always_comb begin
    sep = 1'b0;
    for (int i = 0; i < obbc_pkg::NUM_EDGE; i++) begin
      sep = sep | (acc_q[i] < cen2_q[i]);
    end
    ovl_d = kind_q[4] ? (obbc_pkg::r2u_t'(d2_q) < r2u_q) : !sep;
  end

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      ovl_q <= ovl_d;
    end
  end

  assign rsp_o.valid   = vld_q[5];
  assign rsp_o.overlap = ovl_q;

endmodule

@@ src/obbc_checker.sv @@
// ----------------------------------------------------------------------------
// obbc_checker
// Port-level checks of the overlap test core, bound into the core module.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obbc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input logic overlap_i
);

  `OBBC_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
  `OBBC_ASSERT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> $stable(overlap_i))
  `OBBC_ASSERT_NR(a_ready_when_drained, clk_i, !rsp_valid_i |-> req_ready_i)
  `OBBC_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |=> !rsp_valid_i && req_ready_i)

endmodule

bind obb_circle_overlap_test_2d_core obbc_checker u_obbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .overlap_i   (rsp_o.overlap)
);
